// File: src/tsq_pkg.sv
// Package for the two-square cipher: function codes, letter constants,
// state encoding, square command struct and grid helper functions.
// No dependencies.
package tsq_pkg;

  // Function codes carried in tuser
  localparam logic [2:0] FUNC_KEY_ONE = 3'd0;
  localparam logic [2:0] FUNC_KEY_TWO = 3'd1;
  localparam logic [2:0] FUNC_TEXT    = 3'd2;
  localparam logic [2:0] FUNC_END     = 3'd3;
  localparam logic [2:0] FUNC_CLEAR   = 3'd4;

  // Letter indices
  localparam logic [4:0] LETTER_I   = 5'd8;
  localparam logic [4:0] LETTER_J   = 5'd9;
  localparam logic [4:0] LETTER_X   = 5'd23;
  localparam logic [4:0] LETTER_MAX = 5'd25;
  localparam logic [4:0] CELLS      = 5'd25;
  localparam logic [4:0] LAST_CELL  = 5'd24;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_TEXT,
    ST_LOOK,
    ST_CELL
  } state_e;

  // One cycle of work for a square store
  typedef struct packed {
    logic       clear;
    logic       put;
    logic [4:0] letter;
    logic       place_rd;
    logic [4:0] place_addr;
    logic       cell_rd;
    logic [4:0] cell_addr;
  } sq_cmd_t;

  // J folds onto I
  function automatic logic [4:0] fold_j(input logic [4:0] l);
    return (l == LETTER_J) ? LETTER_I : l;
  endfunction

  // k-th letter of the alphabet without J
  function automatic logic [4:0] plain_order(input logic [4:0] k);
    return (k < LETTER_J) ? k : 5'(k + 5'd1);
  endfunction

  // Row of a grid position 0..24
  function automatic logic [2:0] row_of(input logic [4:0] p);
    logic [2:0] r;
    if (p >= 5'd20) r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5) r = 3'd1;
    else r = 3'd0;
    return r;
  endfunction

  // Column of a grid position 0..24
  function automatic logic [2:0] col_of(input logic [4:0] p);
    logic [2:0] r;
    logic [4:0] base;
    r = row_of(p);
    base = 5'({r, 2'b00}) + 5'(r);
    return 3'(p - base);
  endfunction

  // Grid position from row and column
  function automatic logic [4:0] cell_at(input logic [2:0] r, input logic [2:0] c);
    return 5'({r, 2'b00}) + 5'(r) + 5'(c);
  endfunction

endpackage

// File: src/tsq_square.sv
// One cipher square: cell memory (grid order) and place memory (letter to
// grid position), present flags and fill count.
// Depends on tsq_pkg.
module tsq_square (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tsq_pkg::sq_cmd_t cmd_i,
  output logic [4:0]       place_o,
  output logic [4:0]       cell_o
);

  logic [4:0]  cell_mem [25];
  logic [4:0]  place_mem [26];
  logic [25:0] present_q, present_d;
  logic [4:0]  fill_q, fill_d;
  logic        do_put;

  // A letter is placed only when new and the grid has room
  assign do_put = cmd_i.put && !present_q[cmd_i.letter] && (fill_q < tsq_pkg::CELLS);

  always_comb begin
    present_d = present_q;
    fill_d    = fill_q;
    if (cmd_i.clear) begin
      present_d = '0;
      fill_d    = '0;
    end else if (do_put) begin
      present_d[cmd_i.letter] = 1'b1;
      fill_d = fill_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      fill_q    <= '0;
    end else begin
      present_q <= present_d;
      fill_q    <= fill_d;
    end
  end

  // Memory writes; reads and writes never fall in the same cycle
  always_ff @(posedge clk_i) begin
    if (do_put) begin
      cell_mem[fill_q]         <= cmd_i.letter;
      place_mem[cmd_i.letter]  <= fill_q;
    end
  end

  // Registered reads, held until the next read
  always_ff @(posedge clk_i) begin
    if (cmd_i.place_rd) begin
      place_o <= place_mem[cmd_i.place_addr];
    end
    if (cmd_i.cell_rd) begin
      cell_o <= cell_mem[cmd_i.cell_addr];
    end
  end

endmodule

// File: src/two_square_cipher.sv
// Two-square cipher top: request decode, sequencer, output buffer; needs tsq_pkg, tsq_square.
// A key letter is taken in idle; the first text letter of a pair visits text only. The
// second letter or a padding end visits text, look and cell, waiting in cell while the last
// pair is unread: text reads the places, look the cells, cell loads the output buffer, and
// the two results follow in order. The first text letter after a clear fills both squares
// first. Reset empties the squares, drops the held letter and selects the horizontal layout.
module two_square_cipher (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,     // square_layout
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,    // [4:0] letter, [7:5] zero
  input  logic [2:0] s_axis_tuser,    // [2:0] func
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,    // [4:0] out_letter, [7:5] zero
  output logic       m_axis_tlast     // pair_last
);

  tsq_pkg::state_e  state_q, state_d;
  tsq_pkg::sq_cmd_t cmd_one, cmd_two;

  logic       layout_q;
  logic       done_q, done_d;
  logic [4:0] held_q, held_d;
  logic       held_v_q, held_v_d;
  logic [4:0] pend_q, pend_d;
  logic [4:0] k_q, k_d;
  logic       swap_q, swap_d;
  logic [4:0] place_one, place_two, cell_one, cell_two;
  logic [4:0] o0_q, o0_d, o1_q, o1_d;
  logic [1:0] cnt_q, cnt_d;

  logic       s_acc, m_acc;
  logic [4:0] in_letter, in_fold;
  logic       in_ok;
  logic [2:0] r1, c1, r2, c2;

  assign s_axis_tready = (state_q == tsq_pkg::ST_IDLE);
  assign s_acc     = s_axis_tvalid && s_axis_tready;
  assign m_acc     = m_axis_tvalid && m_axis_tready;
  assign in_letter = s_axis_tdata[4:0];
  assign in_fold   = tsq_pkg::fold_j(in_letter);
  assign in_ok     = (in_letter <= tsq_pkg::LETTER_MAX);

  // Grid coordinates of the pair
  assign r1 = tsq_pkg::row_of(place_one);
  assign c1 = tsq_pkg::col_of(place_one);
  assign r2 = tsq_pkg::row_of(place_two);
  assign c2 = tsq_pkg::col_of(place_two);

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layout_q <= 1'b0;
    end else if (cfg_we_i) begin
      layout_q <= cfg_wdata_i;
    end
  end

  // Sequencer: next state, square commands and output buffer
  always_comb begin
    state_d  = state_q;
    done_d   = done_q;
    held_d   = held_q;
    held_v_d = held_v_q;
    pend_d   = pend_q;
    k_d      = k_q;
    swap_d   = swap_q;
    o0_d     = o0_q;
    o1_d     = o1_q;
    cnt_d    = m_acc ? cnt_q - 2'd1 : cnt_q;
    cmd_one  = '0;
    cmd_two  = '0;

    unique case (state_q)
      tsq_pkg::ST_IDLE: begin
        if (s_acc) begin
          unique case (s_axis_tuser)
            tsq_pkg::FUNC_KEY_ONE: begin
              cmd_one.put    = in_ok && !done_q;
              cmd_one.letter = in_fold;
            end
            tsq_pkg::FUNC_KEY_TWO: begin
              cmd_two.put    = in_ok && !done_q;
              cmd_two.letter = in_fold;
            end
            tsq_pkg::FUNC_TEXT: begin
              if (in_ok) begin
                pend_d  = in_fold;
                k_d     = '0;
                state_d = done_q ? tsq_pkg::ST_TEXT : tsq_pkg::ST_FILL;
              end
            end
            tsq_pkg::FUNC_END: begin
              // pad a held letter with X; squares are already complete
              if (held_v_q) begin
                pend_d  = tsq_pkg::LETTER_X;
                state_d = tsq_pkg::ST_TEXT;
              end
            end
            tsq_pkg::FUNC_CLEAR: begin
              cmd_one.clear = 1'b1;
              cmd_two.clear = 1'b1;
              done_d   = 1'b0;
              held_v_d = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      tsq_pkg::ST_FILL: begin
        // complete both squares with the rest of the alphabet
        cmd_one.put    = 1'b1;
        cmd_one.letter = tsq_pkg::plain_order(k_q);
        cmd_two.put    = 1'b1;
        cmd_two.letter = tsq_pkg::plain_order(k_q);
        k_d = k_q + 5'd1;
        if (k_q == tsq_pkg::LAST_CELL) begin
          done_d  = 1'b1;
          state_d = tsq_pkg::ST_TEXT;
        end
      end

      tsq_pkg::ST_TEXT: begin
        if (held_v_q) begin
          cmd_one.place_rd   = 1'b1;
          cmd_one.place_addr = held_q;
          cmd_two.place_rd   = 1'b1;
          cmd_two.place_addr = pend_q;
          held_v_d = 1'b0;
          state_d  = tsq_pkg::ST_LOOK;
        end else begin
          held_d   = pend_q;
          held_v_d = 1'b1;
          state_d  = tsq_pkg::ST_IDLE;
        end
      end

      tsq_pkg::ST_LOOK: begin
        // swap rows (horizontal) or columns (vertical) across the squares
        cmd_one.cell_rd = 1'b1;
        cmd_two.cell_rd = 1'b1;
        if (!layout_q) begin
          swap_d = (r1 != r2);
          cmd_one.cell_addr = tsq_pkg::cell_at(r2, c1);
          cmd_two.cell_addr = tsq_pkg::cell_at(r1, c2);
        end else begin
          swap_d = (c1 != c2);
          cmd_one.cell_addr = tsq_pkg::cell_at(r1, c2);
          cmd_two.cell_addr = tsq_pkg::cell_at(r2, c1);
        end
        state_d = tsq_pkg::ST_CELL;
      end

      tsq_pkg::ST_CELL: begin
        // wait here until the output buffer is empty
        if (cnt_q == 2'd0) begin
          o0_d    = swap_q ? cell_one : held_q;
          o1_d    = swap_q ? cell_two : pend_q;
          cnt_d   = 2'd2;
          state_d = tsq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tsq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tsq_pkg::ST_IDLE;
      done_q   <= 1'b0;
      held_v_q <= 1'b0;
      k_q      <= '0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      done_q   <= done_d;
      held_v_q <= held_v_d;
      k_q      <= k_d;
      cnt_q    <= cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    held_q <= held_d;
    pend_q <= pend_d;
    swap_q <= swap_d;
    o0_q   <= o0_d;
    o1_q   <= o1_d;
  end

  tsq_square u_square_one (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_one),
    .place_o (place_one),
    .cell_o  (cell_one)
  );

  tsq_square u_square_two (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_two),
    .place_o (place_two),
    .cell_o  (cell_two)
  );

  // Output: first letter while two are pending, second marked last
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = {3'b000, (cnt_q == 2'd2) ? o0_q : o1_q};
  assign m_axis_tlast  = (cnt_q == 2'd1);

endmodule

// File: verif/tsq_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the two-square cipher: watches the layout register, the
// request and result streams, predicts each cipher letter and compares.
// Depends on tsq_pkg for function codes and letter constants.
module tsq_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       s_tvalid_i,
  input  logic       s_tready_i,
  input  logic [7:0] s_tdata_i,    // [4:0] letter, [7:5] zero
  input  logic [2:0] s_tuser_i,    // [2:0] func
  input  logic       m_tvalid_i,
  input  logic       m_tready_i,
  input  logic [7:0] m_tdata_i,    // [4:0] out_letter, [7:5] zero
  input  logic       m_tlast_i,    // pair_last
  output int         mismatches_o,
  output int         pending_o,
  output int         results_o,
  output int         pairs_o
);

  typedef struct {
    logic [4:0] ltr;
    logic       last;
  } cipher_res_t;

  // Shadow copy of the squares; index 0 is square one, 1 is square two
  logic        layout_vert;
  logic [4:0]  grid [2][25];
  logic [4:0]  spot [2][26];
  logic [25:0] used [2];
  int          fill [2];
  logic        squares_built;
  logic [4:0]  held_ltr;
  logic        held_on;

  cipher_res_t cipher_due_q[$];

  task automatic report(input string msg);
    if (mismatches_o < 10) $display("%s", msg);
    mismatches_o++;
  endtask

  task automatic clear_squares();
    for (int s = 0; s < 2; s++) begin
      used[s] = '0;
      fill[s] = 0;
    end
    squares_built = 1'b0;
    held_ltr = '0;
    held_on = 1'b0;
  endtask

  task automatic add_letter(input int sq, input logic [4:0] l);
    logic [4:0] f;
    f = (l == tsq_pkg::LETTER_J) ? tsq_pkg::LETTER_I : l;
    if (f > tsq_pkg::LETTER_MAX || fill[sq] >= 25) return;
    if (used[sq][f]) return;
    grid[sq][fill[sq]] = f;
    spot[sq][f] = 5'(fill[sq]);
    used[sq][f] = 1'b1;
    fill[sq]++;
  endtask

  // Rest of the J-less alphabet, in order
  task automatic complete_square(input int sq);
    for (int k = 0; k < 25; k++) add_letter(sq, 5'((k < 9) ? k : k + 1));
  endtask

  // Swap coordinates across the squares unless the pair shares a row/column
  task automatic push_pair(input logic [4:0] a, input logic [4:0] b);
    int p1, p2, r1, c1, r2, c2;
    cipher_res_t res;
    logic [4:0] o0, o1;
    p1 = spot[0][a];
    p2 = spot[1][b];
    r1 = p1 / 5;
    c1 = p1 % 5;
    r2 = p2 / 5;
    c2 = p2 % 5;
    o0 = a;
    o1 = b;
    if (!layout_vert) begin
      if (r1 != r2) begin
        o0 = grid[0][r2 * 5 + c1];
        o1 = grid[1][r1 * 5 + c2];
      end
    end else if (c1 != c2) begin
      o0 = grid[0][r1 * 5 + c2];
      o1 = grid[1][r2 * 5 + c1];
    end
    res.ltr = o0;
    res.last = 1'b0;
    cipher_due_q.push_back(res);
    res.ltr = o1;
    res.last = 1'b1;
    cipher_due_q.push_back(res);
    pairs_o++;
  endtask

  // Effect of one accepted request on the shadow state
  task automatic cipher_predict(input logic [2:0] func, input logic [4:0] ltr);
    logic [4:0] f;
    f = (ltr == tsq_pkg::LETTER_J) ? tsq_pkg::LETTER_I : ltr;
    case (func)
      tsq_pkg::FUNC_KEY_ONE: begin
        if (ltr <= tsq_pkg::LETTER_MAX && !squares_built) add_letter(0, ltr);
      end
      tsq_pkg::FUNC_KEY_TWO: begin
        if (ltr <= tsq_pkg::LETTER_MAX && !squares_built) add_letter(1, ltr);
      end
      tsq_pkg::FUNC_TEXT: begin
        if (ltr <= tsq_pkg::LETTER_MAX) begin
          if (!squares_built) begin
            complete_square(0);
            complete_square(1);
            squares_built = 1'b1;
          end
          if (!held_on) begin
            held_ltr = f;
            held_on = 1'b1;
          end else begin
            held_on = 1'b0;
            push_pair(held_ltr, f);
          end
        end
      end
      tsq_pkg::FUNC_END: begin
        if (held_on) begin
          held_on = 1'b0;
          push_pair(held_ltr, tsq_pkg::LETTER_X);
        end
      end
      tsq_pkg::FUNC_CLEAR: clear_squares();
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cipher_res_t want;
    if (!rst_ni) begin
      layout_vert = 1'b0;
      clear_squares();
      cipher_due_q.delete();
      mismatches_o = 0;
      results_o = 0;
      pairs_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) layout_vert = cfg_wdata_i;
      // Results: compare with the oldest prediction
      if (m_tvalid_i && m_tready_i) begin
        results_o++;
        if (cipher_due_q.size() == 0) begin
          report($sformatf("unexpected cipher result: tdata %0d last %0b",
                           m_tdata_i, m_tlast_i));
        end else begin
          want = cipher_due_q.pop_front();
          if (m_tdata_i !== {3'b000, want.ltr} || m_tlast_i !== want.last) begin
            report($sformatf({"cipher result mismatch: want letter %0d last %0b,",
                              " got tdata %0d last %0b"},
                             want.ltr, want.last, m_tdata_i, m_tlast_i));
          end
        end
      end
      // Requests
      if (s_tvalid_i && s_tready_i) cipher_predict(s_tuser_i, s_tdata_i[4:0]);
      pending_o = cipher_due_q.size();
    end
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Top of the two-square cipher testbench: clock, reset, request and result
// stimulus with random idling, layout phases and the verdict.
// Depends on tsq_pkg, two_square_cipher and tsq_checker.
module tb_top;

  localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
  localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;
  localparam logic [4:0] LETTER_TOP     = 5'd31;
  localparam int         SETTLE_CYCLES  = 40;
  localparam int         RANDOM_TARGET  = 400;
  localparam int         PHASE_ITEMS    = 50;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;   // [4:0] letter, [7:5] zero
  logic [2:0] s_axis_tuser = '0;   // [2:0] func
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;        // [4:0] out_letter, [7:5] zero
  logic       m_axis_tlast;        // pair_last

  int  mismatches, pending, results, pairs;
  int  sent_total = 0;
  int  random_items = 0;
  int  phases = 0;
  bit  src_idle_on = 1'b1;
  bit  sink_idle_on = 1'b1;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  two_square_cipher dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  tsq_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tlast_i   (m_axis_tlast),
    .mismatches_o(mismatches),
    .pending_o   (pending),
    .results_o   (results),
    .pairs_o     (pairs)
  );

  // One request; called and returns at a falling edge
  task automatic send_request(input logic [2:0] func, input logic [4:0] ltr);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tuser  <= func;
    s_axis_tdata  <= {3'b000, ltr};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    sent_total++;
  endtask

  // Noise requests: bad letters and spare codes the block ignores, and stray keys
  task automatic maybe_noise();
    if ($urandom_range(0, 11) == 0) begin
      case ($urandom_range(0, 2))
        0: send_request(3'($urandom_range(0, 2)), 5'($urandom_range(26, 31)));
        1: send_request(3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI)),
                        5'($urandom_range(0, 31)));
        default: send_request(3'($urandom_range(0, 1)), 5'($urandom_range(0, 25)));
      endcase
    end
  endtask

  task automatic counted(input logic [2:0] func, input logic [4:0] ltr);
    send_request(func, ltr);
    random_items++;
  endtask

  // Random text letter, J a little more often than chance
  function automatic logic [4:0] text_letter();
    return ($urandom_range(0, 7) == 0) ? tsq_pkg::LETTER_J : 5'($urandom_range(0, 25));
  endfunction

  // Usually a clear, then keys for both squares, text, and usually an end of message
  task automatic run_message();
    int nkey1, nkey2, ntext;
    if ($urandom_range(0, 3) != 0) counted(tsq_pkg::FUNC_CLEAR, 5'($urandom_range(0, 31)));
    nkey1 = $urandom_range(0, 12);
    nkey2 = $urandom_range(0, 12);
    while (nkey1 + nkey2 > 0) begin
      if (nkey1 > 0 && (nkey2 == 0 || $urandom_range(0, 1) == 1)) begin
        counted(tsq_pkg::FUNC_KEY_ONE, text_letter());
        nkey1--;
      end else begin
        counted(tsq_pkg::FUNC_KEY_TWO, text_letter());
        nkey2--;
      end
      maybe_noise();
    end
    ntext = $urandom_range(1, 16);
    repeat (ntext) begin
      counted(tsq_pkg::FUNC_TEXT, text_letter());
      maybe_noise();
    end
    if ($urandom_range(0, 3) != 0) counted(tsq_pkg::FUNC_END, 5'($urandom_range(0, 31)));
  endtask

  // Drain all results and let a square fill finish
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_layout(input logic vert);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= vert;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Result side: random stall before each result
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = sink_idle_on ? $urandom_range(0, 18) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    int directed;
    int phase_start;
    logic vert;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_layout(1'b0);

    // Directed: spare codes, key edge cases, J folding, padding, clear
    send_request(FUNC_UNUSED_HI, LETTER_TOP);
    send_request(FUNC_UNUSED_LO, 5'd0);
    send_request(tsq_pkg::FUNC_KEY_ONE, tsq_pkg::LETTER_MAX);
    send_request(tsq_pkg::FUNC_KEY_ONE, tsq_pkg::LETTER_J);
    send_request(tsq_pkg::FUNC_KEY_ONE, tsq_pkg::LETTER_I);
    send_request(tsq_pkg::FUNC_KEY_ONE, LETTER_TOP);
    send_request(tsq_pkg::FUNC_KEY_TWO, 5'd0);
    send_request(tsq_pkg::FUNC_KEY_TWO, tsq_pkg::LETTER_X);
    send_request(tsq_pkg::FUNC_KEY_TWO, 5'd26);
    send_request(tsq_pkg::FUNC_END, 5'd0);
    send_request(tsq_pkg::FUNC_TEXT, 5'd0);
    send_request(tsq_pkg::FUNC_TEXT, tsq_pkg::LETTER_J);
    send_request(tsq_pkg::FUNC_TEXT, tsq_pkg::LETTER_MAX);
    send_request(tsq_pkg::FUNC_KEY_ONE, 5'd3);
    send_request(tsq_pkg::FUNC_END, LETTER_TOP);
    send_request(tsq_pkg::FUNC_TEXT, 5'd30);
    send_request(tsq_pkg::FUNC_TEXT, tsq_pkg::LETTER_I);
    send_request(tsq_pkg::FUNC_TEXT, tsq_pkg::LETTER_I);
    send_request(tsq_pkg::FUNC_TEXT, tsq_pkg::LETTER_X);
    send_request(tsq_pkg::FUNC_CLEAR, 5'd0);
    send_request(tsq_pkg::FUNC_TEXT, 5'd1);
    send_request(tsq_pkg::FUNC_TEXT, tsq_pkg::LETTER_J);
    send_request(tsq_pkg::FUNC_TEXT, tsq_pkg::LETTER_X);
    send_request(tsq_pkg::FUNC_END, 5'd0);
    directed = sent_total;

    // Random phases, alternating layouts, idling on or off per phase
    vert = 1'b0;
    while (random_items < RANDOM_TARGET) begin
      wait_idle();
      vert = ~vert;
      write_layout(vert);
      src_idle_on  = ($urandom_range(0, 2) != 0);
      sink_idle_on = ($urandom_range(0, 2) != 0);
      phase_start = random_items;
      while (random_items - phase_start < PHASE_ITEMS) run_message();
      phases++;
    end

    wait_idle();
    $display("Ran %0d directed and %0d random requests over %0d layout phases.",
             directed, sent_total - directed, phases);
    $display("Checked %0d cipher letters from %0d predicted pairs, %0d mismatches.",
             results, pairs, mismatches);
    if (pending != 0) $display("%0d cipher results never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
